### src/dip_pkg.sv
// Package with the shared types and constants of the decimal integer parser.
package dip_pkg;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_SIGN  = 3'd1,
    PH_DIGIT = 3'd2,
    PH_TRAIL = 3'd3,
    PH_FAIL  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    REG_ALLOW_MINUS    = 2'd0,
    REG_POSITIVE_LIMIT = 2'd1,
    REG_NEGATIVE_LIMIT = 2'd2
  } reg_idx_e;

  localparam int unsigned ValW = 64;
  localparam int unsigned AccW = ValW + 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [ValW-1:0] POS_LIMIT_RST = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValW-1:0] NEG_LIMIT_RST = 64'h8000_0000_0000_0000;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

### src/decimal_integer_parser.sv
// Streaming ASCII decimal integer parser with per-sign magnitude limits.
// A byte is registered on acceptance and scanned in the next cycle. The result of an end
// transfer moves from the input register to the output register, held back only while an
// earlier result is still stalled; the times-ten add and limit compare are combinational.
// Throughput: one byte per cycle, except while an end byte waits on a stalled result.
// Reset: scan state cleared, allow_minus = 1, limits at 2^63-1 and 2^63.
module decimal_integer_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] magnitude
  output logic [1:0]  m_axis_tuser,   // [0] parse_ok, [1] is_negative
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned ValW = dip_pkg::ValW;
  localparam int unsigned AccW = dip_pkg::AccW;

  logic                allow_minus_q;
  logic [ValW-1:0]     pos_limit_q;
  logic [ValW-1:0]     neg_limit_q;

  logic                in_v_q;
  logic [7:0]          in_byte_q;
  logic                in_eot_q;

  dip_pkg::phase_e     phase_q, phase_d;
  logic                minus_q, minus_d;
  logic [ValW-1:0]     acc_q, acc_d;

  logic                out_v_q;
  logic                out_ok_q, out_neg_q;
  logic [ValW-1:0]     out_mag_q;

  logic                advance;
  logic                is_digit;
  logic                is_sp;
  logic [3:0]          digit;
  logic [ValW-1:0]     limit;
  logic [AccW-1:0]     next_val;
  logic                fits;
  logic                res_ok;

  // The registered byte moves on unless it is an end transfer and the result is stalled.
  assign advance       = in_v_q && (!in_eot_q || !out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;

  assign is_digit = (in_byte_q >= dip_pkg::CH_ZERO) && (in_byte_q <= dip_pkg::CH_NINE);
  assign is_sp    = dip_pkg::is_space(in_byte_q);
  assign digit    = 4'(in_byte_q - dip_pkg::CH_ZERO);
  assign limit    = minus_q ? neg_limit_q : pos_limit_q;

  // value*10 + digit as shift-add, compared against the limit at full width.
  assign next_val = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                    + {{(AccW - 4){1'b0}}, digit};
  assign fits     = next_val <= {4'b0000, limit};

  assign res_ok = (phase_q == dip_pkg::PH_DIGIT) || (phase_q == dip_pkg::PH_TRAIL);

  always_comb begin
    phase_d = phase_q;
    minus_d = minus_q;
    acc_d   = acc_q;
    if (in_eot_q) begin
      phase_d = dip_pkg::PH_LEAD;
      minus_d = 1'b0;
      acc_d   = '0;
    end else begin
      unique case (phase_q)
        dip_pkg::PH_LEAD: begin
          if (is_sp) begin
            phase_d = dip_pkg::PH_LEAD;
          end else if (in_byte_q == dip_pkg::CH_PLUS) begin
            phase_d = dip_pkg::PH_SIGN;
          end else if ((in_byte_q == dip_pkg::CH_MINUS) && allow_minus_q) begin
            phase_d = dip_pkg::PH_SIGN;
            minus_d = 1'b1;
          end else if (is_digit && fits) begin
            phase_d = dip_pkg::PH_DIGIT;
            acc_d   = next_val[ValW-1:0];
          end else begin
            phase_d = dip_pkg::PH_FAIL;
          end
        end
        dip_pkg::PH_SIGN, dip_pkg::PH_DIGIT: begin
          if (is_digit && fits) begin
            phase_d = dip_pkg::PH_DIGIT;
            acc_d   = next_val[ValW-1:0];
          end else if (!is_digit && (phase_q == dip_pkg::PH_DIGIT) && is_sp) begin
            phase_d = dip_pkg::PH_TRAIL;
          end else begin
            phase_d = dip_pkg::PH_FAIL;
          end
        end
        dip_pkg::PH_TRAIL: begin
          if (!is_sp) begin
            phase_d = dip_pkg::PH_FAIL;
          end
        end
        default: begin
          phase_d = dip_pkg::PH_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_minus_q <= 1'b1;
      pos_limit_q   <= dip_pkg::POS_LIMIT_RST;
      neg_limit_q   <= dip_pkg::NEG_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dip_pkg::REG_ALLOW_MINUS:    allow_minus_q <= cfg_data_i[0];
        dip_pkg::REG_POSITIVE_LIMIT: pos_limit_q   <= cfg_data_i;
        dip_pkg::REG_NEGATIVE_LIMIT: neg_limit_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      phase_q <= dip_pkg::PH_LEAD;
      minus_q <= 1'b0;
      acc_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (advance) begin
        phase_q <= phase_d;
        minus_q <= minus_d;
        acc_q   <= acc_d;
      end
      if (advance && in_eot_q) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
    if (advance && in_eot_q) begin
      out_ok_q  <= res_ok;
      out_neg_q <= res_ok && minus_q && (acc_q != '0);
      out_mag_q <= res_ok ? acc_q : '0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_mag_q;
  assign m_axis_tuser  = {out_neg_q, out_ok_q};

`ifndef SYNTH
  a_minus_after_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    minus_q |-> (phase_q != dip_pkg::PH_LEAD))
    else $error("minus flag set while still in leading whitespace");

  a_lead_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == dip_pkg::PH_LEAD) |-> (acc_q == '0))
    else $error("accumulator nonzero before any digit");

  a_neg_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_neg_q) |-> (out_ok_q && (out_mag_q != '0)))
    else $error("negative result without a valid nonzero magnitude");

  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(in_v_q && in_eot_q))
    else $error("result raised without an end transfer");
`endif

endmodule

### bench/dip_checker.sv
// Checker for the decimal integer parser: predicts each parse result and compares it.
module dip_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        ok;
    logic        neg;
    logic [63:0] mag;
  } parse_result_t;

  parse_result_t awaited_q[$];

  // Register copies and scan state of the parser as predicted here.
  logic            minus_en;
  logic [63:0]     pos_lim;
  logic [63:0]     neg_lim;
  dip_pkg::phase_e phase;
  logic            minus;
  logic [63:0]     acc;
  int unsigned     errors = 0;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == dip_pkg::CH_SPACE) || (c >= dip_pkg::CH_TAB && c <= dip_pkg::CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= dip_pkg::CH_ZERO && c <= dip_pkg::CH_NINE;
  endfunction

  function automatic void clear_scan();
    phase = dip_pkg::PH_LEAD;
    minus = 1'b0;
    acc   = '0;
  endfunction

  // A digit is taken only when acc * 10 + d stays within the limit of the sign.
  function automatic void absorb_digit(input logic [3:0] d);
    logic [63:0] lim;
    lim = minus ? neg_lim : pos_lim;
    if (lim < 64'(d) || acc > (lim - 64'(d)) / 64'd10) begin
      phase = dip_pkg::PH_FAIL;
    end else begin
      acc   = acc * 64'd10 + 64'(d);
      phase = dip_pkg::PH_DIGIT;
    end
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    case (phase)
      dip_pkg::PH_LEAD: begin
        if (!is_blank(c)) begin
          if (c == dip_pkg::CH_PLUS) begin
            phase = dip_pkg::PH_SIGN;
          end else if (c == dip_pkg::CH_MINUS && minus_en) begin
            minus = 1'b1;
            phase = dip_pkg::PH_SIGN;
          end else if (is_digit(c)) begin
            absorb_digit(4'(c - dip_pkg::CH_ZERO));
          end else begin
            phase = dip_pkg::PH_FAIL;
          end
        end
      end
      dip_pkg::PH_SIGN, dip_pkg::PH_DIGIT: begin
        if (is_digit(c)) begin
          absorb_digit(4'(c - dip_pkg::CH_ZERO));
        end else if (phase == dip_pkg::PH_DIGIT && is_blank(c)) begin
          phase = dip_pkg::PH_TRAIL;
        end else begin
          phase = dip_pkg::PH_FAIL;
        end
      end
      dip_pkg::PH_TRAIL: begin
        if (!is_blank(c)) phase = dip_pkg::PH_FAIL;
      end
      default: begin
        phase = dip_pkg::PH_FAIL;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t want;
    parse_result_t got;
    if (!rst_ni) begin
      minus_en = 1'b1;
      pos_lim  = dip_pkg::POS_LIMIT_RST;
      neg_lim  = dip_pkg::NEG_LIMIT_RST;
      clear_scan();
      awaited_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.ok  = m_tuser_i[0];
        got.neg = m_tuser_i[1];
        got.mag = m_tdata_i;
        if (awaited_q.size() == 0) begin
          errors++;
          $display("%0t: result transfer with none expected, actual ok=%0d neg=%0d mag=%0d",
                   $time, got.ok, got.neg, got.mag);
        end else begin
          want = awaited_q.pop_front();
          if (got.ok !== want.ok) begin
            errors++;
            $display("%0t: parse_ok expected %0d actual %0d", $time, want.ok, got.ok);
          end
          if (got.neg !== want.neg) begin
            errors++;
            $display("%0t: is_negative expected %0d actual %0d", $time, want.neg, got.neg);
          end
          if (got.mag !== want.mag) begin
            errors++;
            $display("%0t: magnitude expected %0d actual %0d", $time, want.mag, got.mag);
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          dip_pkg::REG_ALLOW_MINUS:    minus_en = cfg_data_i[0];
          dip_pkg::REG_POSITIVE_LIMIT: pos_lim  = cfg_data_i;
          dip_pkg::REG_NEGATIVE_LIMIT: neg_lim  = cfg_data_i;
          default: ;
        endcase
      end

      if (s_tvalid_i && s_tready_i) begin
        if (s_tlast_i) begin
          want.ok  = (phase == dip_pkg::PH_DIGIT) || (phase == dip_pkg::PH_TRAIL);
          want.neg = want.ok && minus && (acc != '0);
          want.mag = want.ok ? acc : '0;
          awaited_q.push_back(want);
          clear_scan();
        end else begin
          scan_char(s_tdata_i);
        end
      end
    end
    pending_o <= awaited_q.size();
    errors_o  <= errors;
  end

endmodule

### bench/tb_decimal_integer_parser.sv
// Testbench top for the decimal integer parser: text stimulus, register phases and verdict.
module tb_decimal_integer_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PhaseBytes = 250;
  localparam int unsigned QuietLimit = 2000;
  // The index past the last register; writes to it must change nothing.
  localparam logic [1:0] RegSpare = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  int unsigned pending;
  int unsigned errors;
  int unsigned quiet_cycles = 0;
  int unsigned byte_count = 0;
  bit          calm = 1'b0;
  logic [7:0]  text_q[$];
  logic [63:0] cur_pos = dip_pkg::POS_LIMIT_RST;
  logic [63:0] cur_neg = dip_pkg::NEG_LIMIT_RST;

  decimal_integer_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  dip_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: a random stall before each transfer, none while calm.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic logic [7:0] blank();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    return (pick == 5) ? dip_pkg::CH_SPACE : dip_pkg::CH_TAB + 8'(pick);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    byte_count++;
  endtask

  task automatic send_text();
    if ($urandom_range(0, 7) == 0) calm = !calm;
    foreach (text_q[i]) send_item(text_q[i], 1'b0);
    // The byte of an end transfer carries no character.
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // Mostly well-formed numbers with random content, some near the limits, the rest noise.
  task automatic fill_text();
    int unsigned pick;
    int unsigned n;
    int unsigned at;
    logic        neg;
    logic [63:0] val;
    string       digits;
    text_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom));
    end else begin
      neg = 1'b0;
      repeat ($urandom_range(0, 2)) text_q.push_back(blank());
      case ($urandom_range(0, 3))
        0: text_q.push_back(dip_pkg::CH_PLUS);
        1: begin
          text_q.push_back(dip_pkg::CH_MINUS);
          neg = 1'b1;
        end
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        val = neg ? cur_neg : cur_pos;
        case ($urandom_range(0, 2))
          0: val = val - 64'd1;
          2: val = val + 64'd1;
          default: ;
        endcase
        digits = $sformatf("%0d", val);
        for (int i = 0; i < digits.len(); i++) text_q.push_back(digits[i]);
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 21) : $urandom_range(1, 4);
        repeat (n) text_q.push_back(dip_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
      repeat ($urandom_range(0, 2)) text_q.push_back(blank());
      if (pick >= 85 && text_q.size() != 0) begin
        at = $urandom_range(0, text_q.size() - 1);
        if ($urandom_range(0, 1) == 0) text_q[at] = 8'($urandom);
        else text_q.insert(at, blank());
      end
    end
  endtask

  task automatic random_texts(input int unsigned budget);
    int unsigned start;
    start = byte_count;
    while (byte_count - start < budget) begin
      fill_text();
      send_text();
    end
  endtask

  // Waits until every result has arrived and the block has gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic minus_en, input logic [63:0] pos, input logic [63:0] neg);
    settle();
    cfg_write(RegSpare, {$urandom, $urandom});
    cfg_write(dip_pkg::REG_ALLOW_MINUS, {63'($urandom), minus_en});
    cfg_write(dip_pkg::REG_POSITIVE_LIMIT, pos);
    cfg_write(dip_pkg::REG_NEGATIVE_LIMIT, neg);
    cfg_we_i <= 1'b0;
    cur_pos = pos;
    cur_neg = neg;
    random_texts(PhaseBytes);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_str("");
    send_str(" \t");
    send_str("-");
    send_str("+9\n");
    send_str("-0");
    send_str("1 2");
    send_str("5+");
    text_q = '{8'h00};
    send_text();
    text_q = '{8'hFF};
    send_text();

    random_texts(PhaseBytes);
    run_phase(1'b0, '1, dip_pkg::NEG_LIMIT_RST);
    run_phase(1'b1, '0, '0);
    run_phase(1'b1, 64'($urandom_range(0, 99999)), 64'($urandom_range(0, 99999)));
    run_phase(1'b0, {$urandom, $urandom}, {$urandom, $urandom} >> 1);
    run_phase(1'b1, dip_pkg::POS_LIMIT_RST, dip_pkg::NEG_LIMIT_RST);

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
